// File: hdl/iic_pkg.sv
// Ignition interlock controller: shared codes and constants.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package iic_pkg;

	// Width of the limit registers on the configuration port
	localparam int unsigned CFG_W = 20;

	// Event codes on the request channel
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_HELMET     = 2'd1,
		OP_CONNECT    = 2'd2,
		OP_DISCONNECT = 2'd3
	} opcode_t;

	// Decoded helmet status
	typedef enum logic [1:0] {
		HELMET_SECURE    = 2'd0,
		HELMET_NOT_WORN  = 2'd1,
		HELMET_UNBUCKLED = 2'd2,
		HELMET_UNKNOWN   = 2'd3
	} helmet_code_t;

	// Limit register indexes
	typedef enum logic [1:0] {
		REG_SHORT_WARN = 2'd0,
		REG_LONG_WARN  = 2'd1,
		REG_GRACE      = 2'd2,
		REG_HIBERNATE  = 2'd3
	} reg_index_t;

	// Limit register reset values, in ticks
	localparam logic [CFG_W-1:0] SHORT_WARN_RST = 20'd15000;
	localparam logic [CFG_W-1:0] LONG_WARN_RST  = 20'd60000;
	localparam logic [CFG_W-1:0] GRACE_RST      = 20'd60000;
	localparam logic [CFG_W-1:0] HIBERNATE_RST  = 20'd80000;

endpackage

`default_nettype wire

// File: hdl/ignition_interlock_controller_unit.sv
// Ignition interlock controller: top level.
// Depends on iic_pkg (codes, register reset values).
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Request channel (in_valid / in_stall): one event per request, either a
//  tick with stand, motion and starter samples, a helmet message, a link
//  connect or a link disconnect. Result channel (res_valid / res_stall):
//  one result per request with ignition, buzzer, link, sleep and timer
//  flags after that event.
//  Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//  writes the four tick limits; always ready, write only while idle.
//  A request taken sits in the input register, and its result is loaded
//  from there into the result register once that register is free.
//  Throughput: one request per cycle while the receiver does not stall,
//  set by the single state update between input and result register.
//  When the receiver stalls, the result register holds; the input register
//  still takes one more request, after which in_stall rises until the
//  result is taken. Reset clears all state flags and timers, loads the default
//  limits and empties both registers; no further start-up delay.
module ignition_interlock_controller_unit #(
	parameter int unsigned TIMER_BITS = 20
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               opcode,
	input  wire logic                     stand_up,
	input  wire logic                     riding,
	input  wire logic                     starter_on,
	input  wire logic [1:0]               helmet_code,
	// result channel
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic                          ignition_on,
	output logic                          buzzer_on,
	output logic                          link_up,
	output logic                          sleep_request,
	output logic                          warning_active,
	output logic                          grace_active,
	// configuration channel
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [iic_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned CMP_W = (TIMER_BITS > iic_pkg::CFG_W) ? TIMER_BITS
		: iic_pkg::CFG_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	// saturating increment
	function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] c);
		bump = (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// count >= limit, limit clamped to the counter maximum
	function automatic logic reached(input logic [TIMER_BITS-1:0] c,
		input logic [iic_pkg::CFG_W-1:0] limit);
		logic [CMP_W-1:0] c_ext;
		logic [CMP_W-1:0] l_ext;
		logic [CMP_W-1:0] m_ext;
		c_ext = CMP_W'(c);
		l_ext = CMP_W'(limit);
		m_ext = CMP_W'(CNT_MAX);
		if (l_ext > m_ext) begin
			l_ext = m_ext;
		end
		reached = (c_ext >= l_ext);
	endfunction

	// limit registers
	logic [iic_pkg::CFG_W-1:0] short_warn_q, long_warn_q, grace_lim_q, hibernate_q;

	// controller state
	logic                  link_q, secure_q, worn_q, ign_q, buz_q;
	logic                  warn_run_q, grace_run_q, soff_run_q;
	logic [TIMER_BITS-1:0] warn_cnt_q, grace_cnt_q, soff_cnt_q;

	// input register
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic       stand_s1, riding_s1, starter_s1;
	logic [1:0] helmet_s1;

	// handshake
	logic res_load, in_take;

	assign cfg_ready = 1'b1;
	assign res_load  = valid_s1 && (!res_valid || !res_stall);
	assign in_stall  = valid_s1 && !res_load;
	assign in_take   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_warn_q <= iic_pkg::SHORT_WARN_RST;
			long_warn_q  <= iic_pkg::LONG_WARN_RST;
			grace_lim_q  <= iic_pkg::GRACE_RST;
			hibernate_q  <= iic_pkg::HIBERNATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (iic_pkg::reg_index_t'(cfg_index))
				iic_pkg::REG_SHORT_WARN: short_warn_q <= cfg_data;
				iic_pkg::REG_LONG_WARN:  long_warn_q  <= cfg_data;
				iic_pkg::REG_GRACE:      grace_lim_q  <= cfg_data;
				iic_pkg::REG_HIBERNATE:  hibernate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (res_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1  <= opcode;
			stand_s1   <= stand_up;
			riding_s1  <= riding;
			starter_s1 <= starter_on;
			helmet_s1  <= helmet_code;
		end
	end

	// next state of one event
	logic                  link_d, secure_d, worn_d, ign_d, buz_d;
	logic                  warn_run_d, grace_run_d, soff_run_d, sleep_d;
	logic [TIMER_BITS-1:0] warn_cnt_d, grace_cnt_d, soff_cnt_d;

	always_comb begin
		logic done;
		done        = 1'b0;
		link_d      = link_q;
		secure_d    = secure_q;
		worn_d      = worn_q;
		ign_d       = ign_q;
		buz_d       = buz_q;
		warn_run_d  = warn_run_q;
		warn_cnt_d  = warn_cnt_q;
		grace_run_d = grace_run_q;
		grace_cnt_d = grace_cnt_q;
		soff_run_d  = soff_run_q;
		soff_cnt_d  = soff_cnt_q;
		sleep_d     = 1'b0;
		case (iic_pkg::opcode_t'(opcode_s1))
			iic_pkg::OP_TICK: begin
				// hibernation timer
				if (!starter_s1) begin
					if (!soff_run_q) begin
						soff_run_d = 1'b1;
						soff_cnt_d = '0;
					end else begin
						soff_cnt_d = bump(soff_cnt_q);
						if (reached(soff_cnt_d, hibernate_q)) begin
							done        = 1'b1;
							sleep_d     = 1'b1;
							link_d      = 1'b0;
							secure_d    = 1'b0;
							worn_d      = 1'b0;
							ign_d       = 1'b0;
							buz_d       = 1'b0;
							warn_run_d  = 1'b0;
							warn_cnt_d  = '0;
							grace_run_d = 1'b0;
							grace_cnt_d = '0;
							soff_run_d  = 1'b0;
							soff_cnt_d  = '0;
						end
					end
				end else begin
					soff_run_d = 1'b0;
					soff_cnt_d = '0;
				end
				if (!done) begin
					if (!link_q && grace_run_q) begin
						// disconnect grace period
						grace_cnt_d = bump(grace_cnt_q);
						if (reached(grace_cnt_d, grace_lim_q)) begin
							ign_d       = 1'b0;
							buz_d       = 1'b0;
							grace_run_d = 1'b0;
							grace_cnt_d = '0;
						end
					end else if (link_q) begin
						// safety logic
						if (stand_s1 && secure_q) begin
							ign_d      = 1'b1;
							buz_d      = 1'b0;
							warn_run_d = 1'b0;
							warn_cnt_d = '0;
						end else if (!stand_s1 && !riding_s1 && worn_q) begin
							if (!warn_run_q) begin
								ign_d      = 1'b0;
								warn_run_d = 1'b1;
								warn_cnt_d = '0;
							end else begin
								warn_cnt_d = bump(warn_cnt_q);
							end
							buz_d = 1'b1;
							if (reached(warn_cnt_d, long_warn_q)) begin
								buz_d      = 1'b0;
								warn_run_d = 1'b0;
								warn_cnt_d = '0;
							end
						end else if (riding_s1 && (!stand_s1 || !secure_q)) begin
							if (!warn_run_q) begin
								warn_run_d = 1'b1;
								warn_cnt_d = '0;
							end else begin
								warn_cnt_d = bump(warn_cnt_q);
							end
							if (reached(warn_cnt_d, short_warn_q)) begin
								ign_d      = 1'b0;
								warn_run_d = 1'b0;
								warn_cnt_d = '0;
							end
						end else begin
							ign_d      = 1'b0;
							buz_d      = 1'b0;
							warn_run_d = 1'b0;
							warn_cnt_d = '0;
						end
					end
				end
			end
			iic_pkg::OP_HELMET: begin
				secure_d = (helmet_s1 == iic_pkg::HELMET_SECURE);
				worn_d   = (helmet_s1 == iic_pkg::HELMET_SECURE)
					|| (helmet_s1 == iic_pkg::HELMET_UNBUCKLED);
			end
			iic_pkg::OP_CONNECT: begin
				link_d      = 1'b1;
				grace_run_d = 1'b0;
				grace_cnt_d = '0;
			end
			iic_pkg::OP_DISCONNECT: begin
				link_d      = 1'b0;
				grace_cnt_d = '0;
				if (ign_q) begin
					grace_run_d = 1'b1;
				end else begin
					grace_run_d = 1'b0;
					buz_d       = 1'b0;
					secure_d    = 1'b0;
					worn_d      = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// state update, committed as the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= 1'b0;
			secure_q    <= 1'b0;
			worn_q      <= 1'b0;
			ign_q       <= 1'b0;
			buz_q       <= 1'b0;
			warn_run_q  <= 1'b0;
			warn_cnt_q  <= '0;
			grace_run_q <= 1'b0;
			grace_cnt_q <= '0;
			soff_run_q  <= 1'b0;
			soff_cnt_q  <= '0;
		end else if (res_load) begin
			link_q      <= link_d;
			secure_q    <= secure_d;
			worn_q      <= worn_d;
			ign_q       <= ign_d;
			buz_q       <= buz_d;
			warn_run_q  <= warn_run_d;
			warn_cnt_q  <= warn_cnt_d;
			grace_run_q <= grace_run_d;
			grace_cnt_q <= grace_cnt_d;
			soff_run_q  <= soff_run_d;
			soff_cnt_q  <= soff_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			ignition_on    <= ign_d;
			buzzer_on      <= buz_d;
			link_up        <= link_d;
			sleep_request  <= sleep_d;
			warning_active <= warn_run_d;
			grace_active   <= grace_run_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/iic_checker.sv
// Ignition interlock controller: port checker and its bind to the top level.
// Watches the request and result handshakes; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iic_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire logic ignition_on,
	input wire logic buzzer_on,
	input wire logic link_up,
	input wire logic sleep_request,
	input wire logic warning_active,
	input wire logic grace_active
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its flags
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(ignition_on) && $stable(buzzer_on)
			&& $stable(link_up) && $stable(sleep_request)
			&& $stable(warning_active) && $stable(grace_active))
		else $error("stalled result changed");

	// sleep request comes with everything off, as after a reboot
	a_sleep_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sleep_request |-> !ignition_on && !buzzer_on && !link_up
			&& !warning_active && !grace_active)
		else $error("sleep request with outputs still driven");

	// grace period only runs with the link down
	a_grace_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && grace_active |-> !link_up)
		else $error("grace timer running with link up");

	// with the result register empty the request side never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !in_stall)
		else $error("request stalled with no result pending");

endmodule

bind ignition_interlock_controller_unit iic_checker u_iic_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.ignition_on    (ignition_on),
	.buzzer_on      (buzzer_on),
	.link_up        (link_up),
	.sleep_request  (sleep_request),
	.warning_active (warning_active),
	.grace_active   (grace_active)
);

`default_nettype wire
